// ===== design/rmae_pkg.sv =====
// Shared types and constants of the register machine ALU execute block.
// Depends on nothing; every other design file refers to it by scoped names.
package rmae_pkg;

    localparam int DATA_W      = 32;
    localparam int NUM_REGS    = 4;
    localparam int REG_FIELD_W = 2;
    localparam int FUNC_W      = 4;
    localparam int REG_IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int STEP_CNT_W  = $clog2(DATA_W);

    // Operation codes of the func field.
    localparam logic [FUNC_W-1:0] FUNC_IN   = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_OUT  = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_MOV  = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_XCHG = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_MOD  = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_AND  = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_OR   = 4'd10;
    localparam logic [FUNC_W-1:0] FUNC_XOR  = 4'd11;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [REG_FIELD_W-1:0]   dest_reg;
        logic [REG_FIELD_W-1:0]   src_a_reg;
        logic [REG_FIELD_W-1:0]   src_b_reg;
        logic                     three_operand;
        logic signed [DATA_W-1:0] load_value;
    } t_instr;

    typedef struct packed {
        logic                     out_valid;
        logic signed [DATA_W-1:0] out_data;
        logic                     div_by_zero;
    } t_result;

    typedef enum logic [2:0] {
        MDU_ADD,
        MDU_SUB,
        MDU_MUL,
        MDU_DIV,
        MDU_MOD
    } t_mdu_op;

    typedef struct packed {
        logic              start;
        t_mdu_op           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } t_mdu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_mdu_rsp;

endpackage

// ===== design/rmae_if.sv =====
// Valid/ready channel interfaces for instructions in and results out.
// Depends on rmae_pkg for the payload types.
interface rmae_in_if;
    logic                  valid;
    logic                  ready;
    rmae_pkg::t_instr      payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rmae_out_if;
    logic                  valid;
    logic                  ready;
    rmae_pkg::t_result     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/rmae_regfile.sv =====
// Register file: one write port, one registered read port, valid bits per entry.
// Depends on rmae_pkg for sizes.
module rmae_regfile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rmae_pkg::REG_FIELD_W-1:0]    i_rd_addr,
    output logic [rmae_pkg::DATA_W-1:0]         o_rd_data,
    input  logic                                i_wr_en,
    input  logic [rmae_pkg::REG_FIELD_W-1:0]    i_wr_addr,
    input  logic [rmae_pkg::DATA_W-1:0]         i_wr_data
);

    localparam logic [31:0] NUM_REGS_U = 32'(rmae_pkg::NUM_REGS);

    logic [rmae_pkg::DATA_W-1:0]    r_mem [rmae_pkg::NUM_REGS];
    logic [rmae_pkg::NUM_REGS-1:0]  r_valid;
    logic [rmae_pkg::DATA_W-1:0]    r_rd_data;

    logic                           rd_in_range;
    logic                           wr_in_range;
    logic [rmae_pkg::REG_IDX_W-1:0] rd_idx;
    logic [rmae_pkg::REG_IDX_W-1:0] wr_idx;

    // Indexes past the file read as zero and drop writes.
    assign rd_in_range = 32'(i_rd_addr) < NUM_REGS_U;
    assign wr_in_range = 32'(i_wr_addr) < NUM_REGS_U;
    assign rd_idx      = rmae_pkg::REG_IDX_W'(i_rd_addr);
    assign wr_idx      = rmae_pkg::REG_IDX_W'(i_wr_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en && wr_in_range) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[wr_idx] <= i_wr_data;
        end
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (rd_in_range && r_valid[rd_idx]) begin
            r_rd_data <= r_mem[rd_idx];
        end else begin
            r_rd_data <= '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/rmae_mdu.sv =====
// Shared arithmetic unit: one 33-bit adder used for add/sub, shift-add multiply,
// restoring divide and the final sign fix. Depends on rmae_pkg.
module rmae_mdu (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmae_pkg::t_mdu_req    i_req,
    output rmae_pkg::t_mdu_rsp    o_rsp
);

    localparam int W = rmae_pkg::DATA_W;
    localparam logic [rmae_pkg::STEP_CNT_W-1:0] CNT_LAST = rmae_pkg::STEP_CNT_W'(W - 1);

    typedef enum logic [2:0] {
        M_IDLE,
        M_ARITH,
        M_MUL,
        M_DIV,
        M_FIX
    } t_state;

    t_state                         r_state;
    logic [W-1:0]                   r_acc;      // accumulator / partial remainder
    logic [W-1:0]                   r_opa;      // addend / multiplicand / divisor magnitude
    logic [W-1:0]                   r_opb;      // multiplier / quotient
    logic                           r_sub;
    logic                           r_neg;
    logic                           r_mod;
    logic [rmae_pkg::STEP_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [W-1:0]                   r_result;

    logic [W:0]   add_a;
    logic [W:0]   add_b;
    logic         add_sub;
    logic [W:0]   sum;
    logic [W-1:0] partial;
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic         div_ok;

    assign mag_a   = i_req.a[W-1] ? (~i_req.a + W'(1)) : i_req.a;
    assign mag_b   = i_req.b[W-1] ? (~i_req.b + W'(1)) : i_req.b;
    assign partial = {r_acc[W-2:0], r_opb[W-1]};
    assign div_ok  = !sum[W];

    always_comb begin
        add_a   = {1'b0, r_acc};
        add_b   = {1'b0, r_opa};
        add_sub = r_sub;
        unique case (r_state)
            M_MUL: begin
                add_sub = 1'b0;
            end
            M_DIV: begin
                add_a   = {1'b0, partial};
                add_sub = 1'b1;
            end
            M_FIX: begin
                add_a   = '0;
                add_b   = {1'b0, (r_mod ? r_acc : r_opb)};
                add_sub = r_neg;
            end
            default: begin
            end
        endcase
        sum = add_a + (add_b ^ {(W + 1){add_sub}}) + (W + 1)'(add_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        unique case (i_req.op)
                            rmae_pkg::MDU_ADD, rmae_pkg::MDU_SUB: begin
                                r_acc   <= i_req.a;
                                r_opa   <= i_req.b;
                                r_sub   <= (i_req.op == rmae_pkg::MDU_SUB);
                                r_state <= M_ARITH;
                            end
                            rmae_pkg::MDU_MUL: begin
                                r_acc   <= '0;
                                r_opa   <= i_req.a;
                                r_opb   <= i_req.b;
                                r_state <= M_MUL;
                            end
                            rmae_pkg::MDU_DIV, rmae_pkg::MDU_MOD: begin
                                r_acc   <= '0;
                                r_opa   <= mag_b;
                                r_opb   <= mag_a;
                                r_mod   <= (i_req.op == rmae_pkg::MDU_MOD);
                                // quotient sign from both operands, remainder from dividend
                                r_neg   <= (i_req.op == rmae_pkg::MDU_MOD) ? i_req.a[W-1]
                                           : (i_req.a[W-1] ^ i_req.b[W-1]);
                                r_state <= M_DIV;
                            end
                            default: begin
                                r_state <= M_IDLE;
                            end
                        endcase
                    end
                end
                M_ARITH: begin
                    r_result <= sum[W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                M_MUL: begin
                    if (r_opb[0]) begin
                        r_acc <= sum[W-1:0];
                    end
                    r_opa <= {r_opa[W-2:0], 1'b0};
                    r_opb <= {1'b0, r_opb[W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_result <= r_opb[0] ? sum[W-1:0] : r_acc;
                        r_done   <= 1'b1;
                        r_state  <= M_IDLE;
                    end
                end
                M_DIV: begin
                    r_acc <= div_ok ? sum[W-1:0] : partial;
                    r_opb <= {r_opb[W-2:0], div_ok};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= M_FIX;
                    end
                end
                M_FIX: begin
                    r_result <= sum[W-1:0];
                    r_done   <= 1'b1;
                    r_state  <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

// ===== design/register_machine_alu_execute.sv =====
// Top level of the register machine ALU execute block.
// Depends on rmae_pkg, rmae_if, rmae_regfile and rmae_mdu.
//
// Usage:
//   i_instr  carries one decoded instruction per transaction (func, register
//            indexes, operand form, immediate). A transaction completes on a
//            rising edge with valid and ready both high.
//   o_result carries exactly one result per instruction, in order: out_valid
//            and out_data for an OUT, div_by_zero for a div/mod by zero.
//   The block works on one instruction at a time. i_instr.ready is high only
//   while the sequencer is idle. After an accept the sequencer reads x, then
//   y, then executes; xchg writes its second half, and add/sub/mul and nonzero
//   div/mod wait for the shared unit, before the result enters the output register.
//   The next instruction can be taken in the cycle its predecessor's result
//   is first offered, so a stream of mul/div is paced by the shared adder,
//   which serves multiply and divide one bit per cycle over 32 steps.
//   Reset clears the register file (through valid bits) and leaves both
//   channels empty with i_instr.ready high.
//   When the receiver stalls, the finished result waits in the output
//   register; the block still accepts the next instruction and holds that
//   one's result back until the output register is free.
module register_machine_alu_execute (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmae_in_if.sink      i_instr,
    rmae_out_if.source   o_result
);

    localparam int W = rmae_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_EXEC,
        S_XCHG,
        S_WAIT,
        S_RESULT
    } t_state;

    t_state               r_state;
    rmae_pkg::t_instr     r_instr;
    logic [W-1:0]         r_x;
    logic [W-1:0]         r_y;
    rmae_pkg::t_result    r_res;
    rmae_pkg::t_result    r_out;
    logic                 r_out_v;

    logic [rmae_pkg::REG_FIELD_W-1:0] rd_addr;
    logic [W-1:0]                     rd_data;
    logic                             wr_en;
    logic [rmae_pkg::REG_FIELD_W-1:0] wr_addr;
    logic [W-1:0]                     wr_data;
    rmae_pkg::t_mdu_req               mdu_req;
    rmae_pkg::t_mdu_rsp               mdu_rsp;

    logic in_three;
    logic cur_three;
    logic y_zero;
    logic out_load;

    // Three-operand form only matters for the ALU codes.
    assign in_three  = i_instr.payload.three_operand
                       && (i_instr.payload.func >= rmae_pkg::FUNC_ADD)
                       && (i_instr.payload.func <= rmae_pkg::FUNC_XOR);
    assign cur_three = r_instr.three_operand
                       && (r_instr.func >= rmae_pkg::FUNC_ADD)
                       && (r_instr.func <= rmae_pkg::FUNC_XOR);
    assign y_zero    = (r_y == '0);

    // Move the finished result into the output register once it is free.
    assign out_load  = (r_state == S_RESULT) && (!r_out_v || o_result.ready);

    // Read x while idle (address from the incoming transaction), y while in S_READ_A.
    always_comb begin
        if (r_state == S_READ_A) begin
            rd_addr = cur_three ? r_instr.src_b_reg : r_instr.src_a_reg;
        end else begin
            rd_addr = in_three ? i_instr.payload.src_a_reg : i_instr.payload.dest_reg;
        end
    end

    rmae_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Kick the shared unit for add, sub, mul and nonzero div/mod.
    always_comb begin
        mdu_req.start = 1'b0;
        mdu_req.op    = rmae_pkg::MDU_ADD;
        mdu_req.a     = r_x;
        mdu_req.b     = r_y;
        if (r_state == S_EXEC) begin
            unique case (r_instr.func)
                rmae_pkg::FUNC_ADD: begin
                    mdu_req.start = 1'b1;
                end
                rmae_pkg::FUNC_SUB: begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = rmae_pkg::MDU_SUB;
                end
                rmae_pkg::FUNC_MUL: begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = rmae_pkg::MDU_MUL;
                end
                rmae_pkg::FUNC_DIV: begin
                    mdu_req.start = !y_zero;
                    mdu_req.op    = rmae_pkg::MDU_DIV;
                end
                rmae_pkg::FUNC_MOD: begin
                    mdu_req.start = !y_zero;
                    mdu_req.op    = rmae_pkg::MDU_MOD;
                end
                default: begin
                end
            endcase
        end
    end

    rmae_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    // Register file write port.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_instr.dest_reg;
        wr_data = r_y;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_instr.func)
                    rmae_pkg::FUNC_IN: begin
                        wr_en   = 1'b1;
                        wr_data = r_instr.load_value;
                    end
                    rmae_pkg::FUNC_MOV: begin
                        wr_en   = 1'b1;
                    end
                    rmae_pkg::FUNC_XCHG: begin
                        // first half: old dest goes to src a
                        wr_en   = (r_instr.dest_reg != r_instr.src_a_reg);
                        wr_addr = r_instr.src_a_reg;
                        wr_data = r_x;
                    end
                    rmae_pkg::FUNC_AND: begin
                        wr_en   = 1'b1;
                        wr_data = r_x & r_y;
                    end
                    rmae_pkg::FUNC_OR: begin
                        wr_en   = 1'b1;
                        wr_data = r_x | r_y;
                    end
                    rmae_pkg::FUNC_XOR: begin
                        wr_en   = 1'b1;
                        wr_data = r_x ^ r_y;
                    end
                    default: begin
                    end
                endcase
            end
            S_XCHG: begin
                wr_en = 1'b1;
            end
            S_WAIT: begin
                wr_en   = mdu_rsp.done;
                wr_data = mdu_rsp.result;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, working copies and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            // load a finished result, or drop the one the receiver takes
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && o_result.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_instr.valid) begin
                        r_instr <= i_instr.payload;
                        r_state <= S_READ_A;
                    end
                end
                S_READ_A: begin
                    r_x     <= rd_data;
                    r_state <= S_READ_B;
                end
                S_READ_B: begin
                    r_y     <= rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    unique case (r_instr.func)
                        rmae_pkg::FUNC_OUT: begin
                            r_res   <= '{out_valid: 1'b1, out_data: r_x, div_by_zero: 1'b0};
                            r_state <= S_RESULT;
                        end
                        rmae_pkg::FUNC_XCHG: begin
                            r_res   <= '0;
                            r_state <= (r_instr.dest_reg != r_instr.src_a_reg) ? S_XCHG
                                       : S_RESULT;
                        end
                        rmae_pkg::FUNC_ADD, rmae_pkg::FUNC_SUB, rmae_pkg::FUNC_MUL: begin
                            r_res   <= '0;
                            r_state <= S_WAIT;
                        end
                        rmae_pkg::FUNC_DIV, rmae_pkg::FUNC_MOD: begin
                            // a zero divisor skips the unit and flags the result
                            r_res   <= '{out_valid: 1'b0, out_data: '0, div_by_zero: y_zero};
                            r_state <= y_zero ? S_RESULT : S_WAIT;
                        end
                        default: begin
                            r_res   <= '0;
                            r_state <= S_RESULT;
                        end
                    endcase
                end
                S_XCHG: begin
                    r_state <= S_RESULT;
                end
                S_WAIT: begin
                    if (mdu_rsp.done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_instr.ready    = (r_state == S_IDLE);
    assign o_result.valid   = r_out_v;
    assign o_result.payload = r_out;

endmodule

// ===== design/rmae_chk.sv =====
// Port-level checker for the register machine ALU execute block, with its bind.
// Depends on rmae_pkg for the result type.
module rmae_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input rmae_pkg::t_result   i_out_payload
);

    // Come out of reset idle with nothing pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("block not idle after reset");

    // One transaction at a time: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second transaction accepted while busy");

    // Data and flag fields are mutually exclusive per result.
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_payload.out_valid) |-> (i_out_payload.out_data == '0))
        else $error("out_data nonzero without out_valid");

    a_flag_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_payload.out_valid) |-> !i_out_payload.div_by_zero)
        else $error("out and divide-by-zero flagged together");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled result changed");

endmodule

bind register_machine_alu_execute rmae_chk u_rmae_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_instr.valid),
    .i_in_ready    (i_instr.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_out_payload (o_result.payload)
);
